// ----- src/assert_macros.svh -----
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define FCU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication checked in the next cycle
`define FCU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/fcu_pkg.sv -----
// ----------------------------------------------------------------------------
// fcu_pkg
// Types, widths and codes shared by the frustum cull unit and its checker.
// ----------------------------------------------------------------------------
package fcu_pkg;

    localparam int NUM_PLANES = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam int COORD_W    = 24;
    localparam int NORM_W     = 13;
    localparam int FRAC_SHIFT = 11;                     // Q2.11 * Q16.8 -> 19 fraction bits
    localparam int PROD_W     = NORM_W + COORD_W;       // one normal * coordinate product
    localparam int OFF_W      = COORD_W + 1;            // offset plus sphere radius
    localparam int SHOFF_W    = OFF_W + FRAC_SHIFT;     // offset aligned to the products
    localparam int SUM2_W     = PROD_W + 1;
    localparam int TOT_W      = SUM2_W + 1;

    // capture stage, three evaluation stages, output register
    localparam int META_STAGES = 4;
    localparam int LATENCY     = META_STAGES + 1;

    localparam logic [1:0] FUNC_BOX    = 2'd0;
    localparam logic [1:0] FUNC_SPHERE = 2'd1;
    localparam logic [1:0] FUNC_POINT  = 2'd2;

    typedef struct packed {
        logic                      spare;
        logic signed [COORD_W-1:0] d;
        logic signed [NORM_W-1:0]  c;
        logic signed [NORM_W-1:0]  b;
        logic signed [NORM_W-1:0]  a;
    } plane_t;

    typedef struct packed {
        logic [1:0]                func;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic signed [COORD_W-1:0] ext_x;
        logic signed [COORD_W-1:0] ext_y;
        logic signed [COORD_W-1:0] ext_z;
        logic                      last_in;
    } in_item_t;

    typedef struct packed {
        logic culled;
        logic last_out;
    } out_item_t;

    typedef struct packed {
        logic valid;
        logic known;
        logic last;
    } meta_t;

endpackage

// ----- src/fcu_plane_eval.sv -----
// ----------------------------------------------------------------------------
// fcu_plane_eval
// Three-stage signed distance test of one primitive against one plane.
// ----------------------------------------------------------------------------
module fcu_plane_eval
    import fcu_pkg::*;
(
    input  logic     clk,
    input  plane_t   plane,
    input  in_item_t item,
    output logic     outside
);

    logic                      pick;
    logic                      sphere;
    logic signed [COORD_W-1:0] sel_x;
    logic signed [COORD_W-1:0] sel_y;
    logic signed [COORD_W-1:0] sel_z;
    logic signed [SHOFF_W-1:0] off_shift;
    logic signed [TOT_W-1:0]   total;

    logic signed [PROD_W-1:0]  prod_x_reg, prod_x_next;
    logic signed [PROD_W-1:0]  prod_y_reg, prod_y_next;
    logic signed [PROD_W-1:0]  prod_z_reg, prod_z_next;
    logic signed [OFF_W-1:0]   off_reg, off_next;
    logic signed [SUM2_W-1:0]  sum_xy_reg, sum_xy_next;
    logic signed [SUM2_W-1:0]  sum_zo_reg, sum_zo_next;
    logic                      outside_reg, outside_next;

    always_comb
    begin
        pick   = (item.func == FUNC_BOX);
        sphere = (item.func == FUNC_SPHERE);

        // box corner furthest along the normal
        sel_x = (pick && !plane.a[NORM_W-1]) ? item.ext_x : item.pos_x;
        sel_y = (pick && !plane.b[NORM_W-1]) ? item.ext_y : item.pos_y;
        sel_z = (pick && !plane.c[NORM_W-1]) ? item.ext_z : item.pos_z;

        prod_x_next = PROD_W'(plane.a) * PROD_W'(sel_x);
        prod_y_next = PROD_W'(plane.b) * PROD_W'(sel_y);
        prod_z_next = PROD_W'(plane.c) * PROD_W'(sel_z);

        // value < -r folds into value + r < 0
        off_next = OFF_W'(plane.d) + (sphere ? OFF_W'(item.ext_x) : OFF_W'(0));

        off_shift   = $signed({off_reg, {FRAC_SHIFT{1'b0}}});
        sum_xy_next = SUM2_W'(prod_x_reg) + SUM2_W'(prod_y_reg);
        sum_zo_next = SUM2_W'(prod_z_reg) + SUM2_W'(off_shift);

        total        = TOT_W'(sum_xy_reg) + TOT_W'(sum_zo_reg);
        outside_next = total[TOT_W-1];
    end

    always_ff @(posedge clk)
    begin
        prod_x_reg  <= prod_x_next;
        prod_y_reg  <= prod_y_next;
        prod_z_reg  <= prod_z_next;
        off_reg     <= off_next;
        sum_xy_reg  <= sum_xy_next;
        sum_zo_reg  <= sum_zo_next;
        outside_reg <= outside_next;
    end

    assign outside = outside_reg;

endmodule

// ----- src/frustum_cull_unit.sv -----
// ----------------------------------------------------------------------------
// frustum_cull_unit
// Box, sphere and point culling against six configured frustum planes.
// ----------------------------------------------------------------------------
// One primitive is taken on every cycle that start is high: busy stays low,
// since the pipeline never has to wait on the receiver. Each primitive gives
// one result, shown for a single cycle with done high, after the start
// transfer has passed an input capture stage, the per-plane multiply,
// partial sum and sign stages (six plane units in parallel) and then the
// output register. Results leave in the order primitives arrive. Plane
// registers are read directly by the pipeline, so they should only be
// written while no primitive is in flight; cfg_ready is always high.
module frustum_cull_unit
    import fcu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  in_item_t              item,
    output logic                  done,
    output out_item_t             result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [CFG_DATA_W-1:0] plane_reg [NUM_PLANES];

    in_item_t  item_reg;
    meta_t     meta_reg [META_STAGES];
    meta_t     meta_next;
    logic [NUM_PLANES-1:0] outside;

    logic      done_reg, done_next;
    out_item_t result_reg, result_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PLANES; i++)
            begin
                plane_reg[i] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(NUM_PLANES)))
        begin
            plane_reg[cfg_index] <= cfg_data;
        end
    end

    always_comb
    begin
        meta_next.valid = start && !busy;
        meta_next.known = (item.func == FUNC_BOX) || (item.func == FUNC_SPHERE)
                          || (item.func == FUNC_POINT);
        meta_next.last  = item.last_in;
    end

    // capture stage
    always_ff @(posedge clk)
    begin
        item_reg <= item;
    end

    // valid and side-band bits run alongside the plane units
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < META_STAGES; i++)
            begin
                meta_reg[i] <= '0;
            end
        end
        else
        begin
            meta_reg[0] <= meta_next;
            for (int i = 1; i < META_STAGES; i++)
            begin
                meta_reg[i] <= meta_reg[i-1];
            end
        end
    end

    for (genvar p = 0; p < NUM_PLANES; p++)
    begin : g_plane
        fcu_plane_eval u_plane_eval (
            .clk     (clk),
            .plane   (plane_t'(plane_reg[p])),
            .item    (item_reg),
            .outside (outside[p])
        );
    end

    always_comb
    begin
        done_next            = meta_reg[META_STAGES-1].valid;
        result_next.culled   = meta_reg[META_STAGES-1].known && (|outside);
        result_next.last_out = meta_reg[META_STAGES-1].last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- src/fcu_checker.sv -----
// ----------------------------------------------------------------------------
// fcu_checker
// Port-level timing checks for the frustum cull unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fcu_checker
    import fcu_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input in_item_t  item,
    input logic      done,
    input out_item_t result
);

    logic accepted;

    assign accepted = start && !busy;

    // every transfer in gives a result strobe, and every strobe comes from a transfer in
    `FCU_ASSERT_NOW(a_done_follows_start, accepted, ##LATENCY done, "missing result strobe")
    `FCU_ASSERT_NOW(a_done_has_source, done, $past(accepted, LATENCY), "result with no primitive")
    // batch marker travels with its primitive
    `FCU_ASSERT_NOW(a_last, done, result.last_out == $past(item.last_in, LATENCY), "marker lost")
    // the unit never holds off a start
    `FCU_ASSERT_NEXT(a_never_busy, 1'b1, !busy, "busy raised")

endmodule

bind frustum_cull_unit fcu_checker u_fcu_checker (.*);
